/* hw/rtl/sms_pkg.sv */
// Shared types and constants for the streaming substring matcher.
// No dependencies; imported by every module of the block.
package sms_pkg;

   // Item kinds carried in the request tuser
   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_DOC    = 2'd2,
      ACT_NEWDOC = 2'd3
   } action_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_RED,
      ST_FIN
   } state_type;

   // Strobes broadcast to every cell of the row
   typedef struct packed {
      logic pat_shift;
      logic hist_shift;
      logic sample;
   } cell_ctl_type;

   // Fan-in of the first level of the match reduction
   localparam int GROUP_SIZE = 16;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 32;

endpackage

/* hw/rtl/sms_cell.sv */
// One cell of the matcher row: a pattern byte, a history byte and their compare.
// Depends on sms_pkg for the control struct.
module sms_cell (
   input  logic                      clock,
   input  sms_pkg::cell_ctl_type     ctl,
   input  logic                      active,
   input  logic [sms_pkg::BYTE_W-1:0] pat_in,
   input  logic [sms_pkg::BYTE_W-1:0] hist_in,
   output logic [sms_pkg::BYTE_W-1:0] pat_out,
   output logic [sms_pkg::BYTE_W-1:0] hist_out,
   output logic                      eq
);
   import sms_pkg::*;

   logic [BYTE_W-1:0] pat_ff;
   logic [BYTE_W-1:0] hist_ff;
   logic              eq_ff;

   // Advance the pattern and history bytes toward the far end of the row;
   // sample the compare, cells beyond the pattern length always agree
   always_ff @(posedge clock) begin
      if (ctl.pat_shift) begin
         pat_ff <= pat_in;
      end
      if (ctl.hist_shift) begin
         hist_ff <= hist_in;
      end
      if (ctl.sample) begin
         eq_ff <= !active || (pat_ff == hist_ff);
      end
   end

   assign pat_out  = pat_ff;
   assign hist_out = hist_ff;
   assign eq       = eq_ff;

endmodule

/* hw/rtl/sms_reduce.sv */
// Registered AND reduction of the per-cell compare bits.
// Depends on sms_pkg for the group size.
module sms_reduce #(
   parameter int N = 255
) (
   input  logic         clock,
   input  logic         sample,
   input  logic [N-1:0] eq,
   output logic         all_eq
);
   import sms_pkg::*;

   localparam int NG = (N + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [NG*GROUP_SIZE-1:0] padded;
   logic [NG-1:0]            group_in;
   logic [NG-1:0]            group_ff;

   // Pad the unused top of the last group with ones
   always_comb begin
      padded        = '1;
      padded[N-1:0] = eq;
   end

   // AND within each group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_in[g] = &padded[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   // Hold the group results for the final stage
   always_ff @(posedge clock) begin
      if (sample) begin
         group_ff <= group_in;
      end
   end

   assign all_eq = &group_ff;

endmodule

/* hw/rtl/substring_match_stream.sv */
// Streaming substring matcher: top level with the cell row, reduction and sequencer.
// Depends on sms_pkg, sms_cell and sms_reduce.
//
// The block takes one word at a time on the req_ stream: tuser[1:0] is the action
// (clear pattern, append pattern byte, document byte, start new document) and
// tdata[7:0] the byte. Every word yields exactly one rsp_ word: tuser[0] flags a
// completed occurrence of the pattern, tdata[31:0] its start position (zero when no
// match). Up to MAX_PATTERN pattern bytes are held in a row of cells, newest byte
// at the head, next to the last MAX_PATTERN document bytes, so each cell compares
// its own pair. A document byte shifts the row on acceptance; then ST_CMP samples
// the cell compares, ST_RED registers the grouped AND over 16 cells and ST_FIN
// finishes the reduction into the output register. Other actions go from acceptance
// straight to ST_FIN. A new word is accepted when the sequencer is idle; a finished
// result waits in the output register and the next word may enter meanwhile, but
// that word's result stalls in the last stage until the register is taken.
module substring_match_stream #(
   parameter int MAX_PATTERN = 255
) (
   input  logic        clock,
   input  logic        reset,
   // req_tuser: [1:0] action
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   // req_tdata: [7:0] data_byte
   input  logic [7:0]  req_tdata,
   // rsp_tuser: [0] match_found
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,
   // rsp_tdata: [31:0] match_start
   output logic [31:0] rsp_tdata
);
   import sms_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              pend_doc_ff, pend_doc_in;
   logic [POS_W-1:0]  pend_start_ff, pend_start_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff, out_found_in;
   logic [POS_W-1:0]  out_start_ff, out_start_in;

   action_type        action;
   logic              accept;
   logic              is_doc;
   logic              load_out;
   logic              found;
   logic              all_eq;
   cell_ctl_type      ctl;

   logic [BYTE_W-1:0] pat_q  [MAX_PATTERN];
   logic [BYTE_W-1:0] hist_q [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] active;
   logic [MAX_PATTERN-1:0] eq;

   assign action = action_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign is_doc = (action == ACT_DOC);
   assign found  = pend_doc_ff && all_eq && (len_ff != '0) && (fill_ff >= len_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_doc ? ST_CMP : ST_FIN;
            end
         end
         ST_CMP: state_in = ST_RED;
         ST_RED: state_in = ST_FIN;
         ST_FIN: begin
            if (!out_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready     = 1'b0;
      load_out       = 1'b0;
      ctl.pat_shift  = 1'b0;
      ctl.hist_shift = 1'b0;
      ctl.sample     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            ctl.pat_shift  = req_tvalid && (action == ACT_APPEND) && (len_ff != LEN_MAX);
            ctl.hist_shift = req_tvalid && is_doc;
         end
         ST_CMP: ctl.sample = 1'b1;
         ST_RED: ;
         ST_FIN: load_out = !out_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Pattern length, window fill, position and pending item
   always_comb begin
      len_in        = len_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      pend_doc_in   = pend_doc_ff;
      pend_start_in = pend_start_ff;
      if (accept) begin
         pend_doc_in = 1'b0;
         unique case (action)
            ACT_CLEAR: len_in = '0;
            ACT_APPEND: begin
               if (len_ff != LEN_MAX) begin
                  len_in = len_ff + 1'b1;
               end
            end
            ACT_DOC: begin
               pend_doc_in   = 1'b1;
               pend_start_in = pos_ff - POS_W'(len_ff) + 1'b1;
               if (fill_ff != LEN_MAX) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (pos_ff != '1) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            ACT_NEWDOC: begin
               fill_in = '0;
               pos_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // Output register: drop on handshake, load when the last stage finishes
   always_comb begin
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_start_in = out_start_ff;
      if (rsp_tvalid && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         out_found_in = found;
         out_start_in = found ? pend_start_ff : '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         pend_doc_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         pend_doc_ff  <= pend_doc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_start_ff <= pend_start_in;
      out_found_ff  <= out_found_in;
      out_start_ff  <= out_start_in;
   end

   // Row of cells: cell j holds pattern byte len-1-j and document byte j back
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [BYTE_W-1:0] pat_src;
      logic [BYTE_W-1:0] hist_src;

      if (j == 0) begin : g_head
         assign pat_src  = req_tdata;
         assign hist_src = req_tdata;
      end else begin : g_body
         assign pat_src  = pat_q[j-1];
         assign hist_src = hist_q[j-1];
      end

      assign active[j] = (len_ff > LEN_W'(j));

      sms_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .active   (active[j]),
         .pat_in   (pat_src),
         .hist_in  (hist_src),
         .pat_out  (pat_q[j]),
         .hist_out (hist_q[j]),
         .eq       (eq[j])
      );
   end

   sms_reduce #(
      .N (MAX_PATTERN)
   ) u_reduce (
      .clock  (clock),
      .sample (state_ff == ST_RED),
      .eq     (eq),
      .all_eq (all_eq)
   );

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_found_ff;
   assign rsp_tdata    = out_start_ff;

   // One word in flight: the block is busy in the cycle after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("word accepted while another is in flight");

   // A result without a match carries a zero start
   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero start on a word without a match");

   // Length and fill never pass the row size
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LEN_MAX) && (fill_ff <= LEN_MAX))
      else $error("pattern length or window fill beyond row size");

endmodule
